FILE: hw/rtl/fpbd_pkg.sv
// fpbd_pkg: shared constants, command codes and payload types for the
// packet buffer with duplicate check and range count
// no dependencies
package fpbd_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int SRC_W   = 16;
    localparam int DST_W   = 16;
    localparam int TS_W    = 32;
    localparam int CAP_W   = 7;
    localparam int CNT_W   = 7;

    // ring depth default and capacity reset value
    localparam int DEPTH_DEF = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FWD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CNT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    // saturated count value
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // one stored packet
    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [DST_W-1:0] dst;
        logic [TS_W-1:0]  ts;
    } t_entry;

    // latched input word
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SRC_W-1:0] src;
        logic [DST_W-1:0] dst;
        logic [TS_W-1:0]  ts;
        logic [TS_W-1:0]  t_lo;
        logic [TS_W-1:0]  t_hi;
    } t_item;

    // result word
    typedef struct packed {
        logic             accepted;
        logic             packet_valid;
        logic [SRC_W-1:0] src;
        logic [DST_W-1:0] dst;
        logic [TS_W-1:0]  ts;
        logic [CNT_W-1:0] range_count;
    } t_result;

endpackage

FILE: hw/rtl/fpbd_in_if.sv
// fpbd_in_if: input channel, valid/ready with the command word
// depends on fpbd_pkg
interface fpbd_in_if;
    logic                        valid;
    logic                        ready;
    logic [fpbd_pkg::CMD_W-1:0]  command;
    logic [fpbd_pkg::SRC_W-1:0]  source;
    logic [fpbd_pkg::DST_W-1:0]  destination;
    logic [fpbd_pkg::TS_W-1:0]   timestamp;
    logic [fpbd_pkg::TS_W-1:0]   start_time;
    logic [fpbd_pkg::TS_W-1:0]   end_time;

    modport source_mp (
        output valid, command, source, destination, timestamp, start_time, end_time,
        input  ready
    );
    modport sink (
        input  valid, command, source, destination, timestamp, start_time, end_time,
        output ready
    );
endinterface

FILE: hw/rtl/fpbd_out_if.sv
// fpbd_out_if: result channel, valid/ready with the result word
// depends on fpbd_pkg
interface fpbd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic                        packet_valid;
    logic [fpbd_pkg::SRC_W-1:0]  out_source;
    logic [fpbd_pkg::DST_W-1:0]  out_destination;
    logic [fpbd_pkg::TS_W-1:0]   out_timestamp;
    logic [fpbd_pkg::CNT_W-1:0]  range_count;

    modport source (
        output valid, accepted, packet_valid, out_source, out_destination,
               out_timestamp, range_count,
        input  ready
    );
    modport sink (
        input  valid, accepted, packet_valid, out_source, out_destination,
               out_timestamp, range_count,
        output ready
    );
endinterface

FILE: hw/rtl/fpbd_match.sv
// fpbd_match: shared compare unit, tests one stored entry against the item
// duplicate mode: full triple equal; count mode: destination equal and time in range
// depends on fpbd_pkg
module fpbd_match (
    input  fpbd_pkg::t_entry i_entry,
    input  fpbd_pkg::t_item  i_item,
    input  logic             i_count_mode,
    output logic             o_hit
);

    logic dst_eq;
    logic dup_hit;
    logic range_hit;

    // destination is common to both tests
    assign dst_eq = (i_entry.dst == i_item.dst);

    // full triple match
    assign dup_hit = dst_eq && (i_entry.src == i_item.src) && (i_entry.ts == i_item.ts);

    // inclusive time window, empty when start is above end
    assign range_hit = dst_eq && (i_entry.ts >= i_item.t_lo) && (i_entry.ts <= i_item.t_hi);

    assign o_hit = i_count_mode ? range_hit : dup_hit;

endmodule

FILE: hw/rtl/fifo_packet_buffer_dedup_count_core.sv
// fifo_packet_buffer_dedup_count_core: ring buffer of packets with duplicate check,
// forward of the oldest and destination/time-range count
// depends on fpbd_pkg, fpbd_in_if, fpbd_out_if, fpbd_match
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        command, source, destination, timestamp,
//                                    start_time, end_time
//  o_out     out  valid/ready        accepted, packet_valid, out_source,
//                                    out_destination, out_timestamp, range_count
//  i_cfg     in   i_cfg_we only      capacity_limit
//
// one word at a time: accept, then scan (one ring read per cycle: every stored
// entry for add and count, the oldest for a non-empty forward, none otherwise;
// last compare, exit), then finish
// ready is high only while idle; a finished result waits in the output register, so
// the next word is taken while o_out stalls, and finish waits for that register
// synchronous active-low reset clears pointers and fill level; ring contents need none
module fifo_packet_buffer_dedup_count_core #(
    parameter int BUFFER_DEPTH = fpbd_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fpbd_in_if.sink                     i_in,
    fpbd_out_if.source                  o_out,
    input  logic                        i_cfg_we,
    input  logic [fpbd_pkg::CAP_W-1:0]  i_cfg_wdata
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int LW = (FW > fpbd_pkg::CAP_W) ? FW : fpbd_pkg::CAP_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [AW-1:0] SLOT_LAST = AW'(BUFFER_DEPTH - 1);
    localparam logic [LW-1:0] LIM_MAX   = LW'(BUFFER_DEPTH);

    logic [1:0]                 r_state,     n_state;
    fpbd_pkg::t_item            r_item;
    logic [FW-1:0]              r_scan_len;
    logic [FW-1:0]              r_issue_cnt, n_issue_cnt;
    logic [AW-1:0]              r_rd_slot,   n_rd_slot;
    logic                       r_rd_vld;
    fpbd_pkg::t_entry           r_mem_q;
    logic                       r_dup,       n_dup;
    logic [fpbd_pkg::CNT_W-1:0] r_hits,      n_hits;
    logic [AW-1:0]              r_head,      n_head;
    logic [AW-1:0]              r_tail,      n_tail;
    logic [FW-1:0]              r_fill,      n_fill;
    logic [fpbd_pkg::CAP_W-1:0] r_cap;
    logic                       r_out_valid;
    fpbd_pkg::t_result          r_out;
    fpbd_pkg::t_result          n_out;

    fpbd_pkg::t_entry           mem [BUFFER_DEPTH];

    logic             in_acc;
    logic             rd_en;
    logic             hit;
    logic             out_free;
    logic             finish;
    logic             add_ok;
    logic             fwd_ok;
    logic             evict;
    logic [LW-1:0]    cap_ext;
    logic [LW-1:0]    lim_eff;
    logic [FW-1:0]    len_new;
    fpbd_pkg::t_entry new_entry;

    // handshake and phase strobes
    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign rd_en    = (r_state == ST_SCAN) && (r_issue_cnt != r_scan_len);
    assign out_free = !r_out_valid || o_out.ready;
    assign finish   = (r_state == ST_DONE) && out_free;
    assign add_ok   = (r_item.command == fpbd_pkg::CMD_ADD) && !r_dup;
    assign fwd_ok   = (r_item.command == fpbd_pkg::CMD_FWD) && (r_fill != '0);

    // effective capacity: zero acts as one, clamp to ring depth
    assign cap_ext = LW'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            lim_eff = LW'(1);
        end else if (cap_ext > LIM_MAX) begin
            lim_eff = LIM_MAX;
        end else begin
            lim_eff = cap_ext;
        end
    end
    assign evict = (LW'(r_fill) >= lim_eff) && (r_fill != '0);

    // number of ring reads the new command needs
    always_comb begin
        case (i_in.command)
            fpbd_pkg::CMD_ADD,
            fpbd_pkg::CMD_CNT: len_new = r_fill;
            fpbd_pkg::CMD_FWD: len_new = (r_fill != '0) ? FW'(1) : '0;
            default:           len_new = '0;
        endcase
    end

    assign new_entry = '{src: r_item.src, dst: r_item.dst, ts: r_item.ts};

    // shared compare unit
    fpbd_match u_match (
        .i_entry      (r_mem_q),
        .i_item       (r_item),
        .i_count_mode (r_item.command == fpbd_pkg::CMD_CNT),
        .o_hit        (hit)
    );

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_issue_cnt = r_issue_cnt;
        n_rd_slot   = r_rd_slot;
        n_dup       = r_dup;
        n_hits      = r_hits;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state     = ST_SCAN;
                    n_issue_cnt = '0;
                    n_rd_slot   = r_head;
                    n_dup       = 1'b0;
                    n_hits      = '0;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    n_issue_cnt = r_issue_cnt + 1'b1;
                    n_rd_slot   = (r_rd_slot == SLOT_LAST) ? '0 : r_rd_slot + 1'b1;
                end
                if (r_rd_vld && hit) begin
                    n_dup = 1'b1;
                    if (r_hits != fpbd_pkg::CNT_MAX) begin
                        n_hits = r_hits + 1'b1;
                    end
                end
                if (!rd_en && !r_rd_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // pointer and fill updates at finish
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (finish && add_ok) begin
            n_tail = (r_tail == SLOT_LAST) ? '0 : r_tail + 1'b1;
            if (evict) begin
                n_head = (r_head == SLOT_LAST) ? '0 : r_head + 1'b1;
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end else if (finish && fwd_ok) begin
            n_head = (r_head == SLOT_LAST) ? '0 : r_head + 1'b1;
            n_fill = r_fill - 1'b1;
        end
    end

    // result word
    always_comb begin
        n_out              = '0;
        n_out.accepted     = add_ok;
        n_out.packet_valid = fwd_ok;
        if (fwd_ok) begin
            n_out.src = r_mem_q.src;
            n_out.dst = r_mem_q.dst;
            n_out.ts  = r_mem_q.ts;
        end
        if (r_item.command == fpbd_pkg::CMD_CNT) begin
            n_out.range_count = r_hits;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue_cnt <= '0;
            r_rd_vld    <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_cap       <= fpbd_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue_cnt <= n_issue_cnt;
            r_rd_vld    <= rd_en;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_slot <= n_rd_slot;
        r_dup     <= n_dup;
        r_hits    <= n_hits;
        if (in_acc) begin
            r_item.command <= i_in.command;
            r_item.src     <= i_in.source;
            r_item.dst     <= i_in.destination;
            r_item.ts      <= i_in.timestamp;
            r_item.t_lo    <= i_in.start_time;
            r_item.t_hi    <= i_in.end_time;
            r_scan_len     <= len_new;
        end
        if (finish) begin
            r_out <= n_out;
        end
    end

    // packet ring: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (finish && add_ok) begin
            mem[r_tail] <= new_entry;
        end
        if (rd_en) begin
            r_mem_q <= mem[r_rd_slot];
        end
    end

    // output port
    assign o_out.valid           = r_out_valid;
    assign o_out.accepted        = r_out.accepted;
    assign o_out.packet_valid    = r_out.packet_valid;
    assign o_out.out_source      = r_out.src;
    assign o_out.out_destination = r_out.dst;
    assign o_out.out_timestamp   = r_out.ts;
    assign o_out.range_count     = r_out.range_count;

    // fill level never passes the ring depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FW'(r_fill) <= FW'(BUFFER_DEPTH))
        else $error("fill level above ring depth");

    // ring reads only while scanning and never past the scan length
    a_read_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_issue_cnt < r_scan_len))
        else $error("ring read outside scan");

    // a new result appears only out of the finish state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside finish");

    // forward of a non-empty buffer pops exactly one entry
    a_fwd_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && fwd_ok) |=> (r_fill == $past(r_fill) - 1'b1))
        else $error("forward did not pop one entry");

endmodule

FILE: test/fifo_packet_buffer_dedup_count_core_tb.sv
// fifo_packet_buffer_dedup_count_core_tb: self-checking bench for the packet buffer core,
// directed and random command words checked against a behavioral copy of the ring
// depends on fpbd_pkg, fpbd_in_if, fpbd_out_if and fifo_packet_buffer_dedup_count_core
module fifo_packet_buffer_dedup_count_core_tb;

    localparam int IDLE_PCT   = 36;
    localparam int SETTLE_CYC = 80;
    localparam int SRC_BITS   = fpbd_pkg::SRC_W;
    localparam int DST_BITS   = fpbd_pkg::DST_W;
    localparam int CNT_BITS   = fpbd_pkg::CNT_W;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [fpbd_pkg::CAP_W-1:0] i_cfg_wdata;

    fpbd_in_if  cmd_ch ();
    fpbd_out_if res_ch ();

    fifo_packet_buffer_dedup_count_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (cmd_ch),
        .o_out       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // behavioral copy of the ring and its capacity
    fpbd_pkg::t_entry           ring_copy [fpbd_pkg::DEPTH_DEF];
    int                         head_slot;
    int                         fill_count;
    logic [fpbd_pkg::CAP_W-1:0] capacity_reg;

    fpbd_pkg::t_item   words_to_send [$];
    fpbd_pkg::t_result results_due [$];
    fpbd_pkg::t_item   next_word;
    bit                word_taken;
    bit                send_gaps;
    bit                recv_stalls;
    int                fail_count;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected result of one word, updates the ring copy
    function automatic fpbd_pkg::t_result buffer_apply(fpbd_pkg::t_item w);
        fpbd_pkg::t_result r;
        int      lim;
        int      slot;
        int      hits;
        int      k;
        bit      dup;
        r = '0;
        lim = int'(capacity_reg);
        if (lim < 1) lim = 1;
        if (lim > fpbd_pkg::DEPTH_DEF) lim = fpbd_pkg::DEPTH_DEF;
        case (w.command)
            fpbd_pkg::CMD_ADD: begin
                dup = 1'b0;
                for (k = 0; k < fill_count; k++) begin
                    slot = (head_slot + k) % fpbd_pkg::DEPTH_DEF;
                    if (ring_copy[slot].src == w.src && ring_copy[slot].dst == w.dst &&
                        ring_copy[slot].ts == w.ts)
                        dup = 1'b1;
                end
                if (!dup) begin
                    // full or over capacity: only the single oldest goes
                    if (fill_count >= lim && fill_count > 0) begin
                        head_slot = (head_slot + 1) % fpbd_pkg::DEPTH_DEF;
                        fill_count--;
                    end
                    slot = (head_slot + fill_count) % fpbd_pkg::DEPTH_DEF;
                    ring_copy[slot].src = w.src;
                    ring_copy[slot].dst = w.dst;
                    ring_copy[slot].ts  = w.ts;
                    fill_count++;
                    r.accepted = 1'b1;
                end
            end
            fpbd_pkg::CMD_FWD: begin
                if (fill_count > 0) begin
                    r.packet_valid = 1'b1;
                    r.src = ring_copy[head_slot].src;
                    r.dst = ring_copy[head_slot].dst;
                    r.ts  = ring_copy[head_slot].ts;
                    head_slot = (head_slot + 1) % fpbd_pkg::DEPTH_DEF;
                    fill_count--;
                end
            end
            fpbd_pkg::CMD_CNT: begin
                hits = 0;
                for (k = 0; k < fill_count; k++) begin
                    slot = (head_slot + k) % fpbd_pkg::DEPTH_DEF;
                    if (ring_copy[slot].dst == w.dst && ring_copy[slot].ts >= w.t_lo &&
                        ring_copy[slot].ts <= w.t_hi)
                        hits++;
                end
                if (hits > int'(fpbd_pkg::CNT_MAX)) hits = int'(fpbd_pkg::CNT_MAX);
                r.range_count = CNT_BITS'(hits);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // random word: narrow value pools so duplicates and count hits are common
    function automatic fpbd_pkg::t_item pick_word(int add_pct, int fwd_pct);
        fpbd_pkg::t_item w;
        int    roll;
        w.src  = SRC_BITS'($urandom);
        w.dst  = DST_BITS'($urandom);
        w.ts   = $urandom;
        w.t_lo = $urandom;
        w.t_hi = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
            w.command = fpbd_pkg::CMD_ADD;
        else if (roll < add_pct + fwd_pct)
            w.command = fpbd_pkg::CMD_FWD;
        else if (roll < 96)
            w.command = fpbd_pkg::CMD_CNT;
        else
            w.command = fpbd_pkg::CMD_NONE;
        if ($urandom_range(0, 99) < 70) begin
            w.src = SRC_BITS'($urandom_range(0, 3));
            w.dst = DST_BITS'($urandom_range(0, 3));
            w.ts  = $urandom_range(0, 7);
        end
        if (w.command == fpbd_pkg::CMD_CNT) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                w.t_lo = $urandom_range(0, 7);
                w.t_hi = $urandom_range(w.t_lo, 7);
            end else if (roll < 60) begin
                w.t_lo = '0;
                w.t_hi = '1;
            end else if (roll < 75) begin
                // reversed bounds
                w.t_lo = $urandom_range(1, 7);
                w.t_hi = w.t_lo - 1;
            end
        end
        return w;
    endfunction

    task automatic queue_word(logic [fpbd_pkg::CMD_W-1:0] cmd,
                              logic [fpbd_pkg::SRC_W-1:0] src,
                              logic [fpbd_pkg::DST_W-1:0] dst,
                              logic [fpbd_pkg::TS_W-1:0] ts,
                              logic [fpbd_pkg::TS_W-1:0] t_lo,
                              logic [fpbd_pkg::TS_W-1:0] t_hi);
        fpbd_pkg::t_item w;
        w.command = cmd;
        w.src     = src;
        w.dst     = dst;
        w.ts      = ts;
        w.t_lo    = t_lo;
        w.t_hi    = t_hi;
        words_to_send = {words_to_send, w};
    endtask

    // hold off until every word is sent and every result is back, then settle
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (words_to_send.size() != 0 || cmd_ch.valid || results_due.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [fpbd_pkg::CAP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= value;
        capacity_reg = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count, int add_pct, int fwd_pct);
        repeat (count) words_to_send = {words_to_send, pick_word(add_pct, fwd_pct)};
        wait_drained();
    endtask

    // command driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || word_taken) begin
            if (words_to_send.size() != 0 &&
                !(send_gaps && $urandom_range(0, 99) < IDLE_PCT)) begin
                next_word = words_to_send.pop_front();
                cmd_ch.valid       <= 1'b1;
                cmd_ch.command     <= next_word.command;
                cmd_ch.source      <= next_word.src;
                cmd_ch.destination <= next_word.dst;
                cmd_ch.timestamp   <= next_word.ts;
                cmd_ch.start_time  <= next_word.t_lo;
                cmd_ch.end_time    <= next_word.t_hi;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge i_clk) begin
        res_ch.ready <= !(recv_stalls && $urandom_range(0, 99) < IDLE_PCT);
    end

    // accepted words feed the ring copy, returned words are checked
    always @(posedge i_clk) begin
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                word_taken = 1'b1;
                next_word.command = cmd_ch.command;
                next_word.src     = cmd_ch.source;
                next_word.dst     = cmd_ch.destination;
                next_word.ts      = cmd_ch.timestamp;
                next_word.t_lo    = cmd_ch.start_time;
                next_word.t_hi    = cmd_ch.end_time;
                results_due = {results_due, buffer_apply(next_word)};
            end
            if (res_ch.valid && res_ch.ready) begin
                if (results_due.size() == 0) begin
                    $error("result word with nothing outstanding");
                    fail_count++;
                end else begin
                    automatic fpbd_pkg::t_result want = results_due.pop_front();
                    if (res_ch.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted,
                               res_ch.accepted);
                        fail_count++;
                    end
                    if (res_ch.packet_valid !== want.packet_valid) begin
                        $error("packet_valid: expected %0d, got %0d", want.packet_valid,
                               res_ch.packet_valid);
                        fail_count++;
                    end
                    if (res_ch.out_source !== want.src) begin
                        $error("out_source: expected %0h, got %0h", want.src,
                               res_ch.out_source);
                        fail_count++;
                    end
                    if (res_ch.out_destination !== want.dst) begin
                        $error("out_destination: expected %0h, got %0h", want.dst,
                               res_ch.out_destination);
                        fail_count++;
                    end
                    if (res_ch.out_timestamp !== want.ts) begin
                        $error("out_timestamp: expected %0h, got %0h", want.ts,
                               res_ch.out_timestamp);
                        fail_count++;
                    end
                    if (res_ch.range_count !== want.range_count) begin
                        $error("range_count: expected %0d, got %0d", want.range_count,
                               res_ch.range_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = fpbd_pkg::CMD_NONE;
        cmd_ch.source      = '0;
        cmd_ch.destination = '0;
        cmd_ch.timestamp   = '0;
        cmd_ch.start_time  = '0;
        cmd_ch.end_time    = '0;
        res_ch.ready       = 1'b0;
        head_slot          = 0;
        fill_count         = 0;
        capacity_reg       = fpbd_pkg::CAP_RESET;
        fail_count         = 0;
        word_taken         = 1'b0;
        send_gaps          = 1'b1;
        recv_stalls        = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty buffer, extremes, duplicates, bounds, unused command
        queue_word(fpbd_pkg::CMD_FWD, '1, '1, '1, '1, '1);
        queue_word(fpbd_pkg::CMD_CNT, '0, '0, '0, '0, '1);
        queue_word(fpbd_pkg::CMD_ADD, '0, '0, '0, '1, '1);
        queue_word(fpbd_pkg::CMD_ADD, '0, '0, '0, '0, '0);
        queue_word(fpbd_pkg::CMD_ADD, '1, '1, '1, '0, '0);
        queue_word(fpbd_pkg::CMD_ADD, '1, '0, '0, '0, '0);
        queue_word(fpbd_pkg::CMD_ADD, '0, '1, '0, '0, '0);
        queue_word(fpbd_pkg::CMD_ADD, '0, '0, '1, '0, '0);
        queue_word(fpbd_pkg::CMD_ADD, '1, '1, '1, '0, '0);
        queue_word(fpbd_pkg::CMD_CNT, '1, '0, '1, '0, '1);
        queue_word(fpbd_pkg::CMD_CNT, '0, '1, '0, '1, '1);
        queue_word(fpbd_pkg::CMD_CNT, '0, '0, '0, 32'd1, '0);
        queue_word(fpbd_pkg::CMD_CNT, '0, '0, '0, '0, '0);
        queue_word(fpbd_pkg::CMD_CNT, '0, '0, '0, '1, '0);
        queue_word(fpbd_pkg::CMD_NONE, '1, '1, '1, '1, '1);
        queue_word(fpbd_pkg::CMD_FWD, '0, '0, '0, '0, '0);
        queue_word(fpbd_pkg::CMD_FWD, '0, '0, '0, '0, '0);
        queue_word(fpbd_pkg::CMD_ADD, '0, '0, '0, '0, '0);
        queue_word(fpbd_pkg::CMD_CNT, '0, '0, '0, '0, 32'd0);
        queue_word(fpbd_pkg::CMD_FWD, '0, '0, '0, '0, '0);
        queue_word(fpbd_pkg::CMD_FWD, '0, '0, '0, '0, '0);
        queue_word(fpbd_pkg::CMD_FWD, '0, '0, '0, '0, '0);
        queue_word(fpbd_pkg::CMD_FWD, '0, '0, '0, '0, '0);
        queue_word(fpbd_pkg::CMD_FWD, '0, '0, '0, '0, '0);
        wait_drained();

        // fill to the top and evict
        set_capacity(7'd64);
        run_random(250, 60, 10);
        // capacity dropped well below the fill level
        set_capacity(7'd3);
        run_random(100, 55, 15);
        set_capacity(7'd1);
        run_random(120, 45, 25);
        // zero acts as one
        set_capacity(7'd0);
        run_random(100, 45, 25);
        // above the depth acts as the depth, no idling on either side
        set_capacity(7'd127);
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        run_random(200, 60, 10);
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        set_capacity(7'd65);
        run_random(100, 50, 15);
        set_capacity(7'd17);
        run_random(200, 45, 20);
        set_capacity(7'd64);
        run_random(130, 40, 25);

        if (fail_count == 0) begin
            $display("fifo_packet_buffer_dedup_count_core verification clean");
        end else begin
            $display("fifo_packet_buffer_dedup_count_core verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("fifo_packet_buffer_dedup_count_core verification failed");
        $finish;
    end

endmodule
